// File: rtl/drsc_pkg.sv
// Shared types, mode codes and helpers for the DC motor safe reversal controller.
// No dependencies; every other file imports this package.
package drsc_pkg;

  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_REV  = 2'd1;
  localparam logic [1:0] MODE_STOP = 2'd2;

  localparam int         CFG_CPR     = 0;
  localparam int         CFG_RELOAD  = 1;
  localparam int         CFG_TIMEOUT = 2;
  localparam logic [1:0] CFG_IDX_CPR     = 2'(CFG_CPR);
  localparam logic [1:0] CFG_IDX_RELOAD  = 2'(CFG_RELOAD);
  localparam logic [1:0] CFG_IDX_TIMEOUT = 2'(CFG_TIMEOUT);

  localparam logic [15:0] CPR_RESET     = 16'd1562;
  localparam logic [15:0] RELOAD_RESET  = 16'd999;
  localparam logic [7:0]  TIMEOUT_RESET = 8'd100;

  localparam logic [13:0] ADC_FULL     = 14'd4095;
  localparam logic [13:0] ADC_FULL_X2  = 14'd8190;
  localparam logic [9:0]  SLOW_FACTOR  = 10'd600;
  localparam int          IN_WIDTH     = 32;
  localparam int          OUT_WIDTH    = 40;

  // One classified tick as it travels from the front to the back.
  typedef struct packed {
    logic        cmd_valid;  // some button saw a falling edge
    logic [1:0]  cmd;        // highest-priority command of this tick
    logic [1:0]  req_mode;   // last commanded mode after this tick
    logic        slow;       // near-standstill test on this tick's delta
    logic [11:0] adc;
    logic [15:0] raw_delta;
  } drsc_item_t;

  // Status fields that ride along the compare pipeline.
  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  req_mode;
    logic        waiting;
    logic [15:0] raw_delta;
  } drsc_stat_t;

  function automatic logic [1:0] drsc_prio(input logic [1:0] mode);
    logic [1:0] p;
    case (mode)
      MODE_STOP: p = 2'd3;
      MODE_REV:  p = 2'd2;
      default:   p = 2'd1;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/drsc_front.sv
// Front end: button edge detection, encoder delta and standstill test per tick.
// Depends on drsc_pkg.
module drsc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  logic                 button_forward,
  input  logic                 button_reverse,
  input  logic                 button_stop,
  input  logic [11:0]          adc_sample,
  input  logic [15:0]          encoder_count,
  input  logic [15:0]          counts_per_rev,
  output drsc_pkg::drsc_item_t item
);
  import drsc_pkg::*;

  logic [2:0]  last_buttons;
  logic [15:0] last_encoder_count;
  logic [1:0]  reported_mode;
  logic [2:0]  cur_buttons;
  logic [2:0]  fall;
  logic [15:0] raw;
  logic [16:0] mag;
  logic [26:0] scaled;
  logic [1:0]  cmd;

  assign cur_buttons = {button_stop, button_reverse, button_forward};
  assign fall        = last_buttons & ~cur_buttons;
  assign raw         = encoder_count - last_encoder_count;
  assign mag         = raw[15] ? (17'd0 - {1'b1, raw}) : {1'b0, raw};
  assign scaled      = mag * SLOW_FACTOR;

  // Stop beats reverse beats forward.
  always_comb begin
    if (fall[2]) begin
      cmd = MODE_STOP;
    end else if (fall[1]) begin
      cmd = MODE_REV;
    end else begin
      cmd = MODE_FWD;
    end
  end

  always_comb begin
    item.cmd_valid = |fall;
    item.cmd       = cmd;
    item.req_mode  = (|fall) ? cmd : reported_mode;
    item.slow      = scaled < {11'd0, counts_per_rev};
    item.adc       = adc_sample;
    item.raw_delta = raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_buttons       <= 3'b111;
      last_encoder_count <= 16'd0;
      reported_mode      <= MODE_FWD;
    end else if (accept) begin
      last_buttons       <= cur_buttons;
      last_encoder_count <= encoder_count;
      if (|fall) begin
        reported_mode <= cmd;
      end
    end
  end

endmodule

// File: rtl/drsc_queue.sv
// Two-word queue between the front end and the back end.
// Depends on drsc_pkg for the word type.
module drsc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  drsc_pkg::drsc_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 not_empty,
  output drsc_pkg::drsc_item_t head
);
  import drsc_pkg::*;

  drsc_item_t  slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) full |-> !push || pop)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !not_empty |-> !pop)
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");

endmodule

// File: rtl/drsc_back.sv
// Back end: mode sequencing with the pending slot and slowdown wait, then the
// PWM compare pipeline (multiply, divide by 4095) and the output register.
// Depends on drsc_pkg.
module drsc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  drsc_pkg::drsc_item_t head,
  output logic                 pop,
  input  logic [15:0]          pwm_reload,
  input  logic [7:0]           timeout_ticks,
  output logic                 out_valid,
  input  logic                 out_ready,
  output drsc_pkg::drsc_stat_t out_stat,
  output logic [15:0]          out_compare
);
  import drsc_pkg::*;

  // Controller state.
  logic [1:0] run_mode;
  logic       wait_act;
  logic       wait_tgt;
  logic [7:0] wait_cnt;
  logic       pend_v;
  logic [1:0] pend_mode;

  logic [1:0] run_mode_next;
  logic       wait_act_next;
  logic       wait_tgt_next;
  logic [7:0] wait_cnt_next;
  logic       pend_v_next;
  logic [1:0] pend_mode_next;
  logic       merged_v;
  logic [1:0] merged_mode;

  // Pipeline stages.
  logic        adv;
  logic        s1_v;
  drsc_stat_t  s1_stat;
  logic        s1_en;
  logic [11:0] s1_adc;
  logic        s2_v;
  drsc_stat_t  s2_stat;
  logic [27:0] s2_prod;
  logic        s3_v;
  drsc_stat_t  s3_stat;
  logic [16:0] s3_q;
  logic [13:0] s3_r;
  logic [28:0] prod_sum;
  logic [16:0] q_est;
  logic [29:0] rem_full;
  logic [16:0] q_fix;

  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid;

  always_comb begin
    run_mode_next = run_mode;
    wait_act_next = wait_act;
    wait_tgt_next = wait_tgt;
    wait_cnt_next = wait_cnt;
    merged_v      = pend_v;
    merged_mode   = pend_mode;

    if (head.cmd_valid && (!pend_v || drsc_prio(head.cmd) >= drsc_prio(pend_mode))) begin
      merged_v    = 1'b1;
      merged_mode = head.cmd;
    end
    pend_v_next    = merged_v;
    pend_mode_next = merged_mode;

    if (wait_act) begin
      wait_cnt_next = wait_cnt + 8'd1;
      if (wait_cnt_next >= timeout_ticks || head.slow) begin
        wait_act_next = 1'b0;
        run_mode_next = wait_tgt ? MODE_REV : MODE_FWD;
      end
    end else if (merged_v) begin
      pend_v_next = 1'b0;
      if (merged_mode == MODE_STOP) begin
        run_mode_next = MODE_STOP;
      end else if (merged_mode == run_mode || head.slow) begin
        run_mode_next = merged_mode;
      end else begin
        // Direction change at speed: hold duty at zero until it slows down or the timeout expires.
        wait_act_next = 1'b1;
        wait_tgt_next = merged_mode == MODE_REV;
        wait_cnt_next = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode  <= MODE_STOP;
      wait_act  <= 1'b0;
      wait_tgt  <= 1'b0;
      wait_cnt  <= 8'd0;
      pend_v    <= 1'b0;
      pend_mode <= MODE_FWD;
    end else if (pop) begin
      run_mode  <= run_mode_next;
      wait_act  <= wait_act_next;
      wait_tgt  <= wait_tgt_next;
      wait_cnt  <= wait_cnt_next;
      pend_v    <= pend_v_next;
      pend_mode <= pend_mode_next;
    end
  end

  // The estimate (p + p/4096)/4096 never exceeds p/4095 and is short by less
  // than two, so the remainder stays below three times 4095.
  assign prod_sum = {1'b0, s2_prod} + {13'd0, s2_prod[27:12]};
  assign q_est    = prod_sum[28:12];
  assign rem_full = {2'b0, s2_prod} - {1'b0, q_est, 12'd0} + {13'd0, q_est};

  always_comb begin
    if (s3_r >= ADC_FULL_X2) begin
      q_fix = s3_q + 17'd2;
    end else if (s3_r >= ADC_FULL) begin
      q_fix = s3_q + 17'd1;
    end else begin
      q_fix = s3_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= head_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      out_valid <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_stat.mode      <= run_mode_next;
      s1_stat.req_mode  <= head.req_mode;
      s1_stat.waiting   <= wait_act_next;
      s1_stat.raw_delta <= head.raw_delta;
      s1_en             <= !wait_act_next && run_mode_next != MODE_STOP;
      s1_adc            <= head.adc;

      s2_stat <= s1_stat;
      s2_prod <= s1_en ? (s1_adc * pwm_reload) : 28'd0;

      s3_stat <= s2_stat;
      s3_q    <= q_est;
      s3_r    <= rem_full[13:0];

      out_stat    <= s3_stat;
      out_compare <= q_fix[15:0];
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
      s3_v |-> s3_r < ADC_FULL + ADC_FULL_X2)
    else $error("divide remainder out of correction range");
  a_wait_zero_duty: assert property (@(posedge clk) disable iff (rst)
      out_valid && (out_stat.waiting || out_stat.mode == MODE_STOP) |-> out_compare == 16'd0)
    else $error("nonzero compare while waiting or stopped");
  a_wait_not_stop_target: assert property (@(posedge clk) disable iff (rst)
      wait_act |-> !pend_v || pend_mode == MODE_FWD || pend_mode == MODE_REV
                   || pend_mode == MODE_STOP)
    else $error("invalid pending command while waiting");
  a_pop_only_advance: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> $stable(run_mode) && $stable(wait_act))
    else $error("controller state moved during output stall");

endmodule

// File: rtl/dc_motor_safe_reversal_controller.sv
// DC motor safe reversal controller: one result word for every 10 ms tick word.
// Usage:
//   The input stream carries one tick per word: three active-low button levels,
//   the potentiometer sample and the encoder count. The output stream returns
//   one word per tick with applied and requested mode, the wait flag, bridge
//   pins, PWM compare and the signed encoder delta.
//   Registers are written through cfg_write/cfg_index/cfg_data; the user must
//   do so only while the block is idle, which the block does not enforce.
//   Index 0 counts per revolution, 1 PWM reload, 2 timeout in ticks. One word
//   per cycle is sustained while the receiver is ready. The back end registers
//   the mode step, the adc*reload multiply, the divide estimate and correction.
//   A two-word queue sits between the front end and the back end; when the
//   receiver stalls, the back end holds, the queue fills and s_tready drops.
//   Synchronous reset returns registers to 1562, 999 and 100, the mode to stop,
//   all buttons to released and the encoder reference to zero.
// Depends on drsc_pkg, drsc_front, drsc_queue and drsc_back.
module dc_motor_safe_reversal_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [0] button_forward, [1] button_reverse, [2] button_stop,
  // [14:3] adc_sample, [30:15] encoder_count, [31] zero fill
  input  logic [drsc_pkg::IN_WIDTH-1:0]  s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [1:0] applied_mode, [3:2] requested_mode, [4] waiting_for_slowdown,
  // [5] bridge_enable, [6] bridge_in_a, [7] bridge_in_b,
  // [23:8] pwm_compare, [39:24] count_delta
  output logic [drsc_pkg::OUT_WIDTH-1:0] m_tdata,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import drsc_pkg::*;

  logic [15:0] counts_per_rev;
  logic [15:0] pwm_reload;
  logic [7:0]  timeout_ticks;
  logic        accept;
  logic        q_full;
  logic        q_not_empty;
  logic        q_pop;
  drsc_item_t  front_item;
  drsc_item_t  q_head;
  drsc_stat_t  out_stat;
  logic [15:0] out_compare;
  logic        pin_a;
  logic        pin_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= CPR_RESET;
      pwm_reload     <= RELOAD_RESET;
      timeout_ticks  <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IDX_CPR:     counts_per_rev <= cfg_data;
        CFG_IDX_RELOAD:  pwm_reload     <= cfg_data;
        CFG_IDX_TIMEOUT: timeout_ticks  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  drsc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .button_forward (s_tdata[0]),
    .button_reverse (s_tdata[1]),
    .button_stop    (s_tdata[2]),
    .adc_sample     (s_tdata[14:3]),
    .encoder_count  (s_tdata[30:15]),
    .counts_per_rev (counts_per_rev),
    .item           (front_item)
  );

  drsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  drsc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (q_not_empty),
    .head          (q_head),
    .pop           (q_pop),
    .pwm_reload    (pwm_reload),
    .timeout_ticks (timeout_ticks),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_stat      (out_stat),
    .out_compare   (out_compare)
  );

  // Bridge pins follow the applied mode; while waiting the old direction holds.
  assign pin_a = out_stat.mode == MODE_FWD;
  assign pin_b = out_stat.mode == MODE_REV;

  assign m_tdata = {out_stat.raw_delta, out_compare, pin_b, pin_a, pin_a | pin_b,
                    out_stat.waiting, out_stat.req_mode, out_stat.mode};

endmodule
